// File: hw/rtl/sste_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sste_pkg;

   localparam int SECTOR_BYTES = 256;
   localparam int POS_BITS     = $clog2(SECTOR_BYTES);

   localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(SECTOR_BYTES - 1);

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_STORE   = 3'd1;
   localparam logic [2:0] CMD_FETCH   = 3'd2;
   localparam logic [2:0] CMD_DONE    = 3'd3;
   localparam logic [2:0] CMD_RESTART = 3'd4;

   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   typedef struct packed {
      logic [2:0]          command;
      logic                atn_high;
      logic                clock_high;
      logic                data_high;
      logic                exit_key;
      logic [POS_BITS-1:0] buf_index;
      logic [7:0]          buf_value;
   } item_type;

   typedef struct packed {
      logic       clock_release;
      logic       data_release;
      logic       busy_res;
      logic [1:0] request;
      logic [6:0] req_track;
      logic [6:0] req_sector;
      logic [7:0] fetch_data;
      logic       active;
   } result_type;

   typedef struct packed {
      logic                we;
      logic [POS_BITS-1:0] addr;
      logic [7:0]          data;
   } wr_type;

endpackage

`default_nettype wire

// File: hw/rtl/sste_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

module sste_buffer
   import sste_pkg::*;
(
   input  wire logic                clock,
   input  wire wr_type              wr,
   input  wire logic [POS_BITS-1:0] tx_addr,
   output logic [7:0]               tx_byte,
   input  wire logic                fetch_en,
   input  wire logic [POS_BITS-1:0] fetch_addr,
   output logic [7:0]               fetch_byte
);

   logic [7:0] sector_buffer_ff [SECTOR_BYTES];
   logic [7:0] tx_byte_ff;
   logic [7:0] fetch_byte_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         sector_buffer_ff[wr.addr] <= wr.data;
      end
   end

   // forward a same-edge write so both read ports see the newest byte
   always_ff @(posedge clock) begin
      if (wr.we && (wr.addr == tx_addr)) begin
         tx_byte_ff <= wr.data;
      end else begin
         tx_byte_ff <= sector_buffer_ff[tx_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_en) begin
         if (wr.we && (wr.addr == fetch_addr)) begin
            fetch_byte_ff <= wr.data;
         end else begin
            fetch_byte_ff <= sector_buffer_ff[fetch_addr];
         end
      end
   end

   assign tx_byte    = tx_byte_ff;
   assign fetch_byte = fetch_byte_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sste_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sste_core
   import sste_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire item_type            item,
   input  wire logic [7:0]          tx_byte,
   input  wire logic [7:0]          fetch_byte,
   output result_type               result,
   output wr_type                   wr,
   output logic [POS_BITS-1:0]      tx_addr
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ATN_WAIT, PH_TRK_LOW, PH_TRK_HIGH, PH_SEC_LOW, PH_SEC_HIGH,
      PH_WR_LOW, PH_WR_HIGH, PH_RD_WAIT, PH_TX_LOW, PH_TX_HIGH, PH_WR_WAIT,
      PH_EXITED
   } phase_type;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   phase_type           phase_ff,     phase_in;
   logic [7:0]          shift_ff,     shift_in;
   logic [3:0]          bits_ff,      bits_in;
   logic [POS_BITS-1:0] pos_ff,       pos_in;
   logic [6:0]          track_ff,     track_in;
   logic [6:0]          sector_ff,    sector_in;
   logic                clk_drv_ff,   clk_drv_in;
   logic                dat_drv_ff,   dat_drv_in;

   logic [3:0]          bits_dec;
   logic [7:0]          fetched;
   logic [1:0]          req;

   assign bits_dec = bits_ff - 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      pos_in     = pos_ff;
      track_in   = track_ff;
      sector_in  = sector_ff;
      clk_drv_in = clk_drv_ff;
      dat_drv_in = dat_drv_ff;
      wr         = '0;
      fetched    = 8'd0;

      if (fire) begin
         case (item.command)
            CMD_TICK: begin
               case (phase_ff)
                  PH_IDLE: begin
                     clk_drv_in = 1'b1;
                     dat_drv_in = 1'b1;
                     if (!item.atn_high) begin
                        clk_drv_in = 1'b0;
                        phase_in   = PH_ATN_WAIT;
                     end else if (item.exit_key) begin
                        phase_in = PH_EXITED;
                     end
                  end
                  PH_ATN_WAIT: begin
                     if (item.atn_high) begin
                        clk_drv_in = 1'b1;
                        dat_drv_in = 1'b1;
                        shift_in   = 8'd0;
                        bits_in    = BYTE_BITS;
                        phase_in   = PH_TRK_LOW;
                     end
                  end
                  PH_TRK_LOW, PH_SEC_LOW, PH_WR_LOW: begin
                     if (!item.atn_high) begin
                        clk_drv_in = 1'b1;
                        dat_drv_in = 1'b1;
                        phase_in   = (phase_ff == PH_WR_LOW) ? PH_EXITED : PH_IDLE;
                     end else if (!item.clock_high) begin
                        shift_in = {~item.data_high, shift_ff[7:1]};
                        case (phase_ff)
                           PH_TRK_LOW: phase_in = PH_TRK_HIGH;
                           PH_SEC_LOW: phase_in = PH_SEC_HIGH;
                           default:    phase_in = PH_WR_HIGH;
                        endcase
                     end
                  end
                  PH_TRK_HIGH, PH_SEC_HIGH, PH_WR_HIGH: begin
                     if (item.clock_high) begin
                        bits_in = bits_dec;
                        if (bits_dec != 4'd0) begin
                           case (phase_ff)
                              PH_TRK_HIGH: phase_in = PH_TRK_LOW;
                              PH_SEC_HIGH: phase_in = PH_SEC_LOW;
                              default:     phase_in = PH_WR_LOW;
                           endcase
                        end else begin
                           clk_drv_in = 1'b0;
                           dat_drv_in = 1'b1;
                           case (phase_ff)
                              PH_TRK_HIGH: begin
                                 if (shift_ff[7]) begin
                                    phase_in   = PH_EXITED;
                                    clk_drv_in = 1'b1;
                                 end else begin
                                    track_in   = shift_ff[6:0];
                                    clk_drv_in = 1'b1;
                                    shift_in   = 8'd0;
                                    bits_in    = BYTE_BITS;
                                    phase_in   = PH_SEC_LOW;
                                 end
                              end
                              PH_SEC_HIGH: begin
                                 sector_in = shift_ff[6:0];
                                 pos_in    = '0;
                                 if (shift_ff[7]) begin
                                    phase_in = PH_RD_WAIT;
                                 end else begin
                                    clk_drv_in = 1'b1;
                                    shift_in   = 8'd0;
                                    bits_in    = BYTE_BITS;
                                    phase_in   = PH_WR_LOW;
                                 end
                              end
                              default: begin
                                 wr.we   = 1'b1;
                                 wr.addr = pos_ff;
                                 wr.data = shift_ff;
                                 if (pos_ff == LAST_POS) begin
                                    phase_in = PH_WR_WAIT;
                                 end else begin
                                    pos_in     = pos_ff + 1'b1;
                                    clk_drv_in = 1'b1;
                                    shift_in   = 8'd0;
                                    bits_in    = BYTE_BITS;
                                    phase_in   = PH_WR_LOW;
                                 end
                              end
                           endcase
                        end
                     end
                  end
                  PH_TX_LOW: begin
                     if (!item.atn_high) begin
                        clk_drv_in = 1'b1;
                        dat_drv_in = 1'b1;
                        phase_in   = PH_IDLE;
                     end else if (!item.clock_high) begin
                        dat_drv_in = shift_ff[0];
                        shift_in   = {1'b0, shift_ff[7:1]};
                        phase_in   = PH_TX_HIGH;
                     end
                  end
                  PH_TX_HIGH: begin
                     if (item.clock_high) begin
                        bits_in = bits_dec;
                        if (bits_dec != 4'd0) begin
                           phase_in = PH_TX_LOW;
                        end else if (pos_ff == LAST_POS) begin
                           clk_drv_in = 1'b1;
                           dat_drv_in = 1'b1;
                           phase_in   = PH_IDLE;
                        end else begin
                           pos_in     = pos_ff + 1'b1;
                           clk_drv_in = 1'b1;
                           dat_drv_in = 1'b1;
                           shift_in   = tx_byte;
                           bits_in    = BYTE_BITS;
                           phase_in   = PH_TX_LOW;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CMD_STORE: begin
               wr.we   = 1'b1;
               wr.addr = item.buf_index;
               wr.data = item.buf_value;
            end
            CMD_FETCH: begin
               fetched = fetch_byte;
            end
            CMD_DONE: begin
               if (phase_ff == PH_RD_WAIT) begin
                  pos_in     = '0;
                  clk_drv_in = 1'b1;
                  dat_drv_in = 1'b1;
                  shift_in   = tx_byte;
                  bits_in    = BYTE_BITS;
                  phase_in   = PH_TX_LOW;
               end else if (phase_ff == PH_WR_WAIT) begin
                  clk_drv_in = 1'b1;
                  dat_drv_in = 1'b1;
                  phase_in   = PH_IDLE;
               end
            end
            CMD_RESTART: begin
               clk_drv_in = 1'b1;
               dat_drv_in = 1'b1;
               phase_in   = PH_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   // prefetch the next byte to send: byte zero while a read is pending
   assign tx_addr = (phase_in == PH_RD_WAIT) ? pos_in : pos_in + 1'b1;

   always_comb begin
      case (phase_in)
         PH_RD_WAIT: req = REQ_READ;
         PH_WR_WAIT: req = REQ_WRITE;
         default:    req = REQ_NONE;
      endcase
      result.clock_release = clk_drv_in;
      result.data_release  = dat_drv_in;
      result.busy_res      = !(phase_in inside {PH_IDLE, PH_EXITED});
      result.request       = req;
      result.req_track     = (req != REQ_NONE) ? track_in  : 7'd0;
      result.req_sector    = (req != REQ_NONE) ? sector_in : 7'd0;
      result.fetch_data    = fetched;
      result.active        = (phase_in != PH_EXITED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         shift_ff   <= 8'd0;
         bits_ff    <= 4'd0;
         pos_ff     <= '0;
         track_ff   <= 7'd0;
         sector_ff  <= 7'd0;
         clk_drv_ff <= 1'b1;
         dat_drv_ff <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         bits_ff    <= bits_in;
         pos_ff     <= pos_in;
         track_ff   <= track_in;
         sector_ff  <= sector_in;
         clk_drv_ff <= clk_drv_in;
         dat_drv_ff <= dat_drv_in;
      end
   end

   a_restart_idle: assert property (@(posedge clock) disable iff (reset)
      fire && (item.command == CMD_RESTART) |=> (phase_ff == PH_IDLE))
      else $error("restart did not return to idle");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(pos_ff) && $stable(shift_ff))
      else $error("state moved without a beat");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr.we |-> (item.command == CMD_STORE) || (phase_ff == PH_WR_HIGH))
      else $error("buffer write outside store or receive");

   a_exit_released: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXITED) |-> clk_drv_ff && dat_drv_ff)
      else $error("lines driven after exit");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TX_LOW) || (phase_ff == PH_WR_LOW) |-> (bits_ff != 4'd0)
         && (bits_ff <= BYTE_BITS))
      else $error("bit counter out of range");

endmodule

`default_nettype wire

// File: hw/rtl/serial_sector_transfer_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  beat contents
// req_*     in         tdata: atn_high, clock_high, data_high, exit_key, buf_index,
//                      buf_value; tuser: command
// rsp_*     out        tdata: clock_release, data_release, busy_res, request,
//                      req_track, req_sector, fetch_data, active
//
// One beat per cycle unless results stall; a beat is held in the input register,
// then its result in the output register. Next-state logic feeds the phase registers.
// Reset is synchronous; the sector buffer is not cleared and needs no sweep.
// A stalled result holds the core; one more request beat is buffered meanwhile.

module serial_sector_transfer_engine
   import sste_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] atn_high, [1] clock_high, [2] data_high, [3] exit_key,
   // [11:4] buf_index, [19:12] buf_value, [23:20] zero
   input  wire logic [23:0] req_tdata,
   // [2:0] command
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] clock_release, [1] data_release, [2] busy_res, [4:3] request,
   // [11:5] req_track, [18:12] req_sector, [26:19] fetch_data, [27] active,
   // [31:28] zero
   output logic [31:0]      rsp_tdata
);

   logic                in_valid_ff;
   item_type            item_ff;
   logic                rsp_valid_ff;
   result_type          rsp_ff;
   logic                fire;
   logic                req_accept;
   result_type          result;
   wr_type              wr;
   logic [POS_BITS-1:0] tx_addr;
   logic [7:0]          tx_byte;
   logic [7:0]          fetch_byte;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.command    <= req_tuser;
         item_ff.atn_high   <= req_tdata[0];
         item_ff.clock_high <= req_tdata[1];
         item_ff.data_high  <= req_tdata[2];
         item_ff.exit_key   <= req_tdata[3];
         item_ff.buf_index  <= req_tdata[11:4];
         item_ff.buf_value  <= req_tdata[19:12];
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   sste_buffer u_buffer (
      .clock      (clock),
      .wr         (wr),
      .tx_addr    (tx_addr),
      .tx_byte    (tx_byte),
      .fetch_en   (req_accept),
      .fetch_addr (req_tdata[11:4]),
      .fetch_byte (fetch_byte)
   );

   sste_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item_ff),
      .tx_byte    (tx_byte),
      .fetch_byte (fetch_byte),
      .result     (result),
      .wr         (wr),
      .tx_addr    (tx_addr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.active, rsp_ff.fetch_data, rsp_ff.req_sector,
                        rsp_ff.req_track, rsp_ff.request, rsp_ff.busy_res,
                        rsp_ff.data_release, rsp_ff.clock_release};

endmodule

`default_nettype wire

// File: bench/serial_sector_transfer_engine_test.sv
`timescale 1ns / 1ps

module serial_sector_transfer_engine_test;
   import sste_pkg::*;

   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
   localparam int         ITEM_TARGET     = 800;
   localparam int         REPORT_LIMIT    = 10;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ATN_WAIT, PH_TRACK_LOW, PH_TRACK_HIGH, PH_SECTOR_LOW, PH_SECTOR_HIGH,
      PH_WRITE_LOW, PH_WRITE_HIGH, PH_READ_WAIT, PH_SEND_LOW, PH_SEND_HIGH, PH_WRITE_WAIT,
      PH_EXITED
   } link_phase_type;

   class loader_tracker;
      link_phase_type phase;
      logic [7:0]    shifter;
      logic [3:0]    bits_left;
      logic [7:0]    byte_pos;
      logic [6:0]    track;
      logic [7:0]    sector;
      logic [7:0]    buffer [SECTOR_BYTES];
      logic          clock_drive;
      logic          data_drive;
      result_type    awaited_results [$];
      int            mismatches;
      int            results_checked;

      function new();
         phase = PH_IDLE;
         shifter = '0;
         bits_left = '0;
         byte_pos = '0;
         track = '0;
         sector = '0;
         clock_drive = 1'b1;
         data_drive = 1'b1;
         mismatches = 0;
         results_checked = 0;
      endfunction

      function void go_idle();
         phase = PH_IDLE;
         clock_drive = 1'b1;
         data_drive = 1'b1;
      endfunction

      function void start_receive(link_phase_type next_phase);
         clock_drive = 1'b1;
         data_drive = 1'b1;
         shifter = '0;
         bits_left = 4'd8;
         phase = next_phase;
      endfunction

      function void start_send();
         clock_drive = 1'b1;
         data_drive = 1'b1;
         shifter = buffer[byte_pos];
         bits_left = 4'd8;
         phase = PH_SEND_LOW;
      endfunction

      function void finish_received_byte();
         clock_drive = 1'b0;
         data_drive = 1'b1;
         case (phase)
            PH_TRACK_HIGH: begin
               if (shifter[7]) begin
                  phase = PH_EXITED;
                  clock_drive = 1'b1;
               end else begin
                  track = shifter[6:0];
                  start_receive(PH_SECTOR_LOW);
               end
            end
            PH_SECTOR_HIGH: begin
               sector = shifter;
               byte_pos = '0;
               if (shifter[7]) phase = PH_READ_WAIT;
               else start_receive(PH_WRITE_LOW);
            end
            default: begin
               buffer[byte_pos] = shifter;
               if (byte_pos == LAST_POS) begin
                  phase = PH_WRITE_WAIT;
               end else begin
                  byte_pos = byte_pos + 8'd1;
                  start_receive(PH_WRITE_LOW);
               end
            end
         endcase
      endfunction

      function void sample_lines(logic atn, logic clk, logic dat, logic key);
         case (phase)
            PH_IDLE: begin
               clock_drive = 1'b1;
               data_drive = 1'b1;
               if (!atn) begin
                  clock_drive = 1'b0;
                  phase = PH_ATN_WAIT;
               end else if (key) begin
                  phase = PH_EXITED;
               end
            end
            PH_ATN_WAIT: if (atn) start_receive(PH_TRACK_LOW);
            PH_TRACK_LOW, PH_SECTOR_LOW, PH_WRITE_LOW: begin
               if (!atn) begin
                  if (phase == PH_WRITE_LOW) begin
                     phase = PH_EXITED;
                     clock_drive = 1'b1;
                     data_drive = 1'b1;
                  end else begin
                     go_idle();
                  end
               end else if (!clk) begin
                  shifter = {~dat, shifter[7:1]};
                  if (phase == PH_TRACK_LOW) phase = PH_TRACK_HIGH;
                  else if (phase == PH_SECTOR_LOW) phase = PH_SECTOR_HIGH;
                  else phase = PH_WRITE_HIGH;
               end
            end
            PH_TRACK_HIGH, PH_SECTOR_HIGH, PH_WRITE_HIGH: begin
               if (clk) begin
                  bits_left = bits_left - 4'd1;
                  if (bits_left == 4'd0) finish_received_byte();
                  else if (phase == PH_TRACK_HIGH) phase = PH_TRACK_LOW;
                  else if (phase == PH_SECTOR_HIGH) phase = PH_SECTOR_LOW;
                  else phase = PH_WRITE_LOW;
               end
            end
            PH_SEND_LOW: begin
               if (!atn) begin
                  go_idle();
               end else if (!clk) begin
                  data_drive = shifter[0];
                  shifter = shifter >> 1;
                  phase = PH_SEND_HIGH;
               end
            end
            PH_SEND_HIGH: begin
               if (clk) begin
                  bits_left = bits_left - 4'd1;
                  if (bits_left != 4'd0) begin
                     phase = PH_SEND_LOW;
                  end else if (byte_pos == LAST_POS) begin
                     go_idle();
                  end else begin
                     byte_pos = byte_pos + 8'd1;
                     start_send();
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void note_beat(item_type beat);
         result_type want;
         logic [7:0] fetched;
         fetched = '0;
         case (beat.command)
            CMD_TICK: sample_lines(beat.atn_high, beat.clock_high, beat.data_high,
                                   beat.exit_key);
            CMD_STORE: buffer[beat.buf_index] = beat.buf_value;
            CMD_FETCH: fetched = buffer[beat.buf_index];
            CMD_DONE: begin
               if (phase == PH_READ_WAIT) begin
                  byte_pos = '0;
                  start_send();
               end else if (phase == PH_WRITE_WAIT) begin
                  go_idle();
               end
            end
            CMD_RESTART: go_idle();
            default: ;
         endcase
         want = '0;
         want.clock_release = clock_drive;
         want.data_release = data_drive;
         want.busy_res = (phase != PH_IDLE && phase != PH_EXITED);
         if (phase == PH_READ_WAIT) want.request = REQ_READ;
         else if (phase == PH_WRITE_WAIT) want.request = REQ_WRITE;
         else want.request = REQ_NONE;
         if (want.request != REQ_NONE) begin
            want.req_track = track;
            want.req_sector = sector[6:0];
         end
         want.fetch_data = fetched;
         want.active = (phase != PH_EXITED);
         awaited_results.push_back(want);
      endfunction

      function void compare_field(string name, int expected, int actual);
         if (expected != actual) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d: %s expected %0h, got %0h", results_checked, name,
                        expected, actual);
         end
      endfunction

      function void check_beat(logic [31:0] word);
         result_type want;
         results_checked++;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d: beat %h arrived with nothing pending", results_checked,
                        word);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("clock_release", want.clock_release, word[0]);
         compare_field("data_release", want.data_release, word[1]);
         compare_field("busy_res", want.busy_res, word[2]);
         compare_field("request", want.request, word[4:3]);
         compare_field("req_track", want.req_track, word[11:5]);
         compare_field("req_sector", want.req_sector, word[18:12]);
         compare_field("fetch_data", want.fetch_data, word[26:19]);
         compare_field("active", want.active, word[27]);
         compare_field("padding", 0, word[31:28]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   loader_tracker book;
   bit req_calm;
   bit rsp_calm;
   bit buffer_full;
   int beats_sent;
   int full_writes;
   int full_reads;
   int broken_sessions;

   serial_sector_transfer_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic rbit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic bit one_in(int n);
      return $urandom_range(0, n - 1) == 0;
   endfunction

   task automatic send_beat(input logic [2:0] cmd, input logic atn, clk, dat, key,
                            input logic [7:0] idx, val);
      item_type beat;
      int gap;
      beat.command = cmd;
      beat.atn_high = atn;
      beat.clock_high = clk;
      beat.data_high = dat;
      beat.exit_key = key;
      beat.buf_index = idx;
      beat.buf_value = val;
      if (one_in(40)) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0000, val, idx, key, dat, clk, atn};
      do @(posedge clock); while (req_tready !== 1'b1);
      book.note_beat(beat);
      beats_sent++;
   endtask

   task automatic line_tick(input logic atn, clk, dat);
      logic key;
      key = (book.phase == PH_IDLE && atn) ? 1'b0 : rbit();
      send_beat(CMD_TICK, atn, clk, dat, key, 8'($urandom), 8'($urandom));
   endtask

   task automatic restart_loader();
      send_beat(CMD_RESTART, rbit(), rbit(), rbit(), rbit(), 8'($urandom), 8'($urandom));
   endtask

   task automatic buffer_op();
      if (rbit())
         send_beat(CMD_STORE, rbit(), rbit(), rbit(), rbit(), 8'($urandom), 8'($urandom));
      else
         send_beat(CMD_FETCH, rbit(), rbit(), rbit(), rbit(), 8'($urandom), 8'($urandom));
   endtask

   task automatic maybe_buffer_op();
      if (buffer_full && one_in(10)) buffer_op();
   endtask

   task automatic send_host_byte(input logic [7:0] value);
      for (int i = 0; i < 8; i++) begin
         maybe_buffer_op();
         if (one_in(4)) line_tick(1'b1, 1'b1, rbit());
         line_tick(1'b1, 1'b0, ~value[i]);
         if (one_in(4)) line_tick(rbit(), 1'b0, rbit());
         line_tick(rbit(), 1'b1, rbit());
      end
   endtask

   task automatic take_device_byte();
      for (int i = 0; i < 8; i++) begin
         maybe_buffer_op();
         if (one_in(4)) line_tick(1'b1, 1'b1, rbit());
         line_tick(1'b1, 1'b0, rbit());
         if (one_in(4)) line_tick(rbit(), 1'b0, rbit());
         line_tick(rbit(), 1'b1, rbit());
      end
   endtask

   task automatic raise_attention();
      repeat ($urandom_range(1, 3)) line_tick(1'b0, rbit(), rbit());
      line_tick(1'b1, rbit(), rbit());
   endtask

   task automatic write_session(input int nbytes);
      raise_attention();
      send_host_byte(8'($urandom_range(0, 127)));
      send_host_byte(8'($urandom_range(0, 127)));
      repeat (nbytes) send_host_byte(8'($urandom));
      if (nbytes == SECTOR_BYTES) begin
         repeat ($urandom_range(0, 3)) line_tick(rbit(), rbit(), rbit());
         send_beat(CMD_DONE, rbit(), rbit(), rbit(), rbit(), 8'($urandom), 8'($urandom));
         full_writes++;
         buffer_full = 1'b1;
      end else begin
         line_tick(1'b0, rbit(), rbit());
         repeat ($urandom_range(0, 2)) line_tick(rbit(), rbit(), rbit());
         restart_loader();
         broken_sessions++;
      end
   endtask

   task automatic read_session(input int nbytes);
      raise_attention();
      send_host_byte(8'($urandom_range(0, 127)));
      send_host_byte(8'h80 | 8'($urandom_range(0, 127)));
      repeat ($urandom_range(0, 3)) line_tick(rbit(), rbit(), rbit());
      send_beat(CMD_DONE, rbit(), rbit(), rbit(), rbit(), 8'($urandom), 8'($urandom));
      repeat (nbytes) take_device_byte();
      if (nbytes == SECTOR_BYTES) begin
         full_reads++;
      end else begin
         line_tick(1'b0, rbit(), rbit());
         broken_sessions++;
      end
   endtask

   task automatic header_break();
      logic [15:0] bits;
      int nbits;
      bits = 16'($urandom);
      bits[7] = 1'b0;
      nbits = $urandom_range(0, 15);
      raise_attention();
      for (int i = 0; i < nbits; i++) begin
         line_tick(1'b1, 1'b0, ~bits[i]);
         line_tick(rbit(), 1'b1, rbit());
      end
      line_tick(1'b0, rbit(), rbit());
      broken_sessions++;
   endtask

   task automatic exit_by_track();
      raise_attention();
      send_host_byte(8'h80 | 8'($urandom_range(0, 127)));
      repeat ($urandom_range(1, 3)) line_tick(rbit(), rbit(), rbit());
      restart_loader();
      broken_sessions++;
   endtask

   task automatic exit_by_key();
      send_beat(CMD_TICK, 1'b1, rbit(), rbit(), 1'b1, 8'($urandom), 8'($urandom));
      repeat ($urandom_range(1, 3)) line_tick(rbit(), rbit(), rbit());
      restart_loader();
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(5, 30))
         send_beat(3'($urandom_range(0, 7)), rbit(), rbit(), rbit(), rbit(), 8'($urandom),
                   8'($urandom));
      restart_loader();
      broken_sessions++;
   endtask

   task automatic directed_cases();
      send_beat(CMD_STORE, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00);
      send_beat(CMD_STORE, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff, 8'hff);
      send_beat(CMD_STORE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h5a, 8'ha5);
      send_beat(CMD_FETCH, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'hff);
      send_beat(CMD_FETCH, 1'b1, 1'b1, 1'b1, 1'b0, 8'hff, 8'h00);
      send_beat(CMD_FETCH, 1'b0, 1'b0, 1'b0, 1'b1, 8'h5a, 8'h00);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         send_beat(3'(c), 1'b0, 1'b0, 1'b0, 1'b1, 8'hff, 8'hff);
      send_beat(CMD_DONE, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00);
      send_beat(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00);
      send_beat(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
      send_beat(CMD_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
      send_beat(CMD_FETCH, 1'b1, 1'b1, 1'b1, 1'b0, 8'hff, 8'h00);
      send_beat(CMD_RESTART, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00);
      send_beat(CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00);
      send_beat(CMD_STORE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h01, 8'h3c);
      send_beat(CMD_FETCH, 1'b0, 1'b0, 1'b0, 1'b0, 8'h01, 8'h00);
      send_beat(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00);
      send_beat(CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00);
      send_beat(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
      send_beat(CMD_RESTART, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff, 8'hff);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (one_in(40)) rsp_calm = !rsp_calm;
         if (!rsp_calm && !one_in(3)) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) book.check_beat(rsp_tdata);
   end

   initial begin
      #40ms;
      $display("serial_sector_transfer_engine_test failed");
      $finish;
   end

   initial begin
      int mark;
      int pick;
      int light_beats;
      int extra_full;
      bit full_run;
      book = new();
      light_beats = 0;
      extra_full = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      directed_cases();
      write_session(SECTOR_BYTES);
      read_session(SECTOR_BYTES);

      while (light_beats < ITEM_TARGET) begin
         mark = beats_sent;
         full_run = 1'b0;
         pick = $urandom_range(0, 31);
         if (pick <= 1 && extra_full < 2) begin
            full_run = 1'b1;
            extra_full++;
            if (pick == 0) write_session(SECTOR_BYTES);
            else read_session(SECTOR_BYTES);
         end else if (pick <= 9) begin
            write_session($urandom_range(0, 4));
         end else if (pick <= 17) begin
            read_session($urandom_range(0, 4));
         end else if (pick <= 21) begin
            header_break();
         end else if (pick <= 23) begin
            exit_by_track();
         end else if (pick <= 25) begin
            exit_by_key();
         end else if (pick <= 28) begin
            noise_burst();
         end else begin
            repeat ($urandom_range(1, 8)) buffer_op();
            send_beat(CMD_DONE, rbit(), rbit(), rbit(), rbit(), 8'($urandom), 8'($urandom));
         end
         if (!full_run) light_beats += beats_sent - mark;
      end

      @(negedge clock) req_tvalid <= 1'b0;
      while (book.awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d request beats and %0d result beats, with %0d whole-sector writes",
               beats_sent, book.results_checked, full_writes);
      $display("and %0d whole-sector reads; %0d sessions cut short by resync, exit or noise",
               full_reads, broken_sessions);
      if (book.mismatches == 0 && book.awaited_results.size() == 0)
         $display("serial_sector_transfer_engine_test passed");
      else
         $display("serial_sector_transfer_engine_test failed");
      $finish;
   end

endmodule

// File: serial_sector_transfer_engine.f
hw/rtl/sste_pkg.sv
hw/rtl/sste_buffer.sv
hw/rtl/sste_core.sv
hw/rtl/serial_sector_transfer_engine.sv
bench/serial_sector_transfer_engine_test.sv
